>>> rtl/frame_time_average_and_rate_defines.svh
// assertion macros for the frame timer
`ifndef FRAME_TIME_AVERAGE_AND_RATE_DEFINES_SVH
`define FRAME_TIME_AVERAGE_AND_RATE_DEFINES_SVH
`ifndef SYNTHESIS
`define FTAR_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("frame timer assertion failed");
`define FTAR_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("frame timer assertion failed");
`else
`define FTAR_ASSERT(lbl, ck, rn, prop)
`define FTAR_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

>>> rtl/ftar_pkg.sv
// types, constants and event codes of the frame timer
package ftar_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = 32 + $clog2(WINDOW_DEPTH);
    localparam int DIV_CW       = $clog2(SUM_W + 1);

    localparam logic [31:0] TPS_RESET = 32'd10000000;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] counter_now;
    } ftar_in_t;

    typedef struct packed {
        logic [31:0] average_frame_ticks;
        logic [15:0] frame_rate;
        logic [62:0] total_ticks;
        logic        is_stopped;
    } ftar_out_t;

    typedef struct packed {
        logic load_in;
        logic calc_diff;
        logic update;
        logic test;
        logic push;
        logic div_load;
        logic div_step;
        logic div_end;
        logic tot1;
        logic tot2;
        logic load_out;
    } ftar_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic div_done;
    } ftar_stat_t;

endpackage

>>> rtl/ftar_ram.sv
// generic single-port-write ram with registered read
module ftar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ftar_dp.sv
// frame timer datapath: counters, sample window, rate window, divider, output register
module ftar_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data,
    input  ftar_pkg::ftar_in_t   in_data,
    input  ftar_pkg::ftar_cmd_t  cmd,
    output ftar_pkg::ftar_stat_t stat,
    output ftar_pkg::ftar_out_t  out_data
);
    import ftar_pkg::*;

    logic [31:0]       tps_reg;
    ftar_in_t          in_reg;
    logic [63:0]       diff_reg;
    logic [31:0]       d_reg;
    logic              accept_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [31:0]       avg_reg;
    logic [63:0]       last_reg;
    logic [63:0]       current_reg;
    logic [63:0]       base_reg;
    logic [63:0]       paused_reg;
    logic [63:0]       stop_reg;
    logic              stopped_reg;
    logic [15:0]       tally_reg;
    logic [32:0]       accum_reg;
    logic [15:0]       rate_reg;
    logic [CNT_W:0]    rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic [DIV_CW-1:0] dcnt_reg;
    logic [63:0]       tot_reg;
    ftar_out_t         out_reg;

    logic [31:0]       old_sample;
    logic [31:0]       abs_diff;
    logic [15:0]       tally_inc;
    logic [32:0]       accum_sum;
    logic              window_full;
    logic [IDX_W-1:0]  head_inc;
    logic [CNT_W:0]    trial;
    logic              trial_ge;
    logic              ram_we;

    ftar_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (d_reg),
        .re    (cmd.test),
        .raddr (head_reg),
        .rdata (old_sample)
    );

    assign abs_diff    = (d_reg >= avg_reg) ? (d_reg - avg_reg) : (avg_reg - d_reg);
    assign tally_inc   = (tally_reg == 16'hFFFF) ? tally_reg : tally_reg + 16'd1;
    assign accum_sum   = accum_reg + {1'b0, d_reg};
    assign window_full = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign head_inc    = (head_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign ram_we      = cmd.push && accept_reg;
    assign trial       = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign trial_ge    = (trial >= {1'b0, divisor_reg});

    assign stat.tick_run = (in_reg.kind == KIND_TICK) && !stopped_reg;
    assign stat.div_done = (dcnt_reg == DIV_CW'(SUM_W - 1));
    assign out_data      = out_reg;

    // timer and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg     <= TPS_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            avg_reg     <= '0;
            last_reg    <= '0;
            current_reg <= '0;
            base_reg    <= '0;
            paused_reg  <= '0;
            stop_reg    <= '0;
            stopped_reg <= 1'b0;
            tally_reg   <= '0;
            accum_reg   <= '0;
            rate_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                unique case (in_reg.kind)
                    KIND_TICK:
                    begin
                        if (stopped_reg)
                        begin
                            avg_reg <= '0;
                        end
                        else
                        begin
                            current_reg <= in_reg.counter_now;
                            last_reg    <= in_reg.counter_now;
                        end
                    end
                    KIND_START:
                    begin
                        if (stopped_reg)
                        begin
                            paused_reg  <= paused_reg + diff_reg;
                            last_reg    <= in_reg.counter_now;
                            stop_reg    <= '0;
                            stopped_reg <= 1'b0;
                        end
                    end
                    KIND_STOP:
                    begin
                        if (!stopped_reg)
                        begin
                            stop_reg    <= in_reg.counter_now;
                            stopped_reg <= 1'b1;
                        end
                    end
                    KIND_RESET:
                    begin
                        base_reg    <= in_reg.counter_now;
                        last_reg    <= in_reg.counter_now;
                        stop_reg    <= '0;
                        stopped_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.test)
            begin
                if (accum_sum > {1'b0, tps_reg})
                begin
                    rate_reg  <= tally_inc;
                    tally_reg <= '0;
                    accum_reg <= '0;
                end
                else
                begin
                    tally_reg <= tally_inc;
                    accum_reg <= accum_sum;
                end
            end
            if (ram_we)
            begin
                // oldest sample leaves once the window is full
                sum_reg  <= sum_reg + SUM_W'(d_reg)
                            - (window_full ? SUM_W'(old_sample) : '0);
                head_reg <= head_inc;
                if (!window_full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.div_end)
            begin
                avg_reg <= (count_reg == '0) ? '0 : quo_reg[31:0];
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.calc_diff)
        begin
            diff_reg <= in_reg.counter_now
                        - ((in_reg.kind == KIND_START) ? stop_reg : last_reg);
        end
        if (cmd.update)
        begin
            d_reg <= (|diff_reg[63:32]) ? 32'hFFFF_FFFF : diff_reg[31:0];
        end
        if (cmd.test)
        begin
            accept_reg <= (abs_diff < tps_reg);
        end
        if (cmd.div_load)
        begin
            rem_reg     <= '0;
            quo_reg     <= sum_reg;
            divisor_reg <= count_reg;
            dcnt_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            rem_reg  <= trial_ge ? (trial - {1'b0, divisor_reg}) : trial;
            quo_reg  <= {quo_reg[SUM_W-2:0], trial_ge};
            dcnt_reg <= dcnt_reg + DIV_CW'(1);
        end
        if (cmd.tot1)
        begin
            tot_reg <= (stopped_reg ? stop_reg : current_reg) - paused_reg;
        end
        if (cmd.tot2)
        begin
            tot_reg <= tot_reg - base_reg;
        end
        if (cmd.load_out)
        begin
            out_reg.average_frame_ticks <= avg_reg;
            out_reg.frame_rate          <= rate_reg;
            out_reg.total_ticks         <= tot_reg[63] ? '0 : tot_reg[62:0];
            out_reg.is_stopped          <= stopped_reg;
        end
    end

endmodule

>>> rtl/ftar_ctrl.sv
// frame timer controller: sequencing state machine and output valid
`include "frame_time_average_and_rate_defines.svh"
module ftar_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ftar_pkg::ftar_stat_t stat,
    output ftar_pkg::ftar_cmd_t  cmd
);
    import ftar_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_TEST   = 4'd3;
    localparam logic [3:0] S_PUSH   = 4'd4;
    localparam logic [3:0] S_DIVLD  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DIVEND = 4'd7;
    localparam logic [3:0] S_TOT1   = 4'd8;
    localparam logic [3:0] S_TOT2   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [10:0] cmd_vec;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = stat.tick_run ? S_TEST : S_TOT1;
            end
            S_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND:
            begin
                cmd.div_end = 1'b1;
                state_next  = S_TOT1;
            end
            S_TOT1:
            begin
                cmd.tot1   = 1'b1;
                state_next = S_TOT2;
            end
            S_TOT2:
            begin
                cmd.tot2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd_vec = {cmd.calc_diff, cmd.update, cmd.test, cmd.push, cmd.div_load,
                      cmd.div_step, cmd.div_end, cmd.tot1, cmd.tot2, cmd.load_out,
                      cmd.load_in};

    `FTAR_ASSERT(a_accept_blocks, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    `FTAR_ASSERT(a_load_free, clk, rst_n, cmd.load_out |-> (!out_valid_reg || out_ready))
    `FTAR_ASSERT(a_div_ends, clk, rst_n, (cmd.div_step && stat.div_done) |=> cmd.div_end)
    `FTAR_ASSERT_ALWAYS(a_one_cmd, clk, $onehot0(cmd_vec))

endmodule

>>> rtl/frame_time_average_and_rate.sv
// frame timer top level: event channel in, timing result channel out
//
// input channel (in_valid / in_ready / in_data) carries one event per
// transaction: tick, start, stop or reset, stamped with the free-running
// counter value. every event yields exactly one result transaction on the
// output channel (out_valid / out_ready / out_data): average frame time,
// latched frame rate, total running ticks and the paused flag.
// ticks_per_second is to be written through cfg_we / cfg_data only
// while idle; the block itself does not enforce this. one event is in
// flight at a time. a tick while running passes through the sample
// test, the window push and the restoring divider that forms the window
// mean one quotient bit per cycle; other events skip these steps.
// in_ready rises again in the cycle after the result is loaded.
// the result sits in an output register: the next event is accepted while
// it waits, and a new result is only loaded once the old one is taken.
// reset clears the timer counters, the window fill and the rate window
// and sets ticks_per_second to 10000000; window contents need no clearing.
module frame_time_average_and_rate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  ftar_pkg::ftar_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ftar_pkg::ftar_out_t out_data
);
    import ftar_pkg::*;

    ftar_cmd_t  cmd;
    ftar_stat_t stat;

    ftar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ftar_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

>>> bench/tb_frame_time_average_and_rate.sv
// testbench for the frame timer: random event stream checked against a timing predictor
`timescale 1ns / 100ps

module tb_frame_time_average_and_rate;
    import ftar_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    ftar_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    ftar_out_t   out_data;

    ftar_in_t    pending_events[$];
    ftar_out_t   expected_timing[$];
    ftar_out_t   want;
    ftar_out_t   got;
    int          errors = 0;
    int          cycle_count = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    logic        idle_on = 1'b1;
    logic [63:0] stamp = '0;

    // timing predictor state
    logic [31:0] tps_model = TPS_RESET;
    logic [31:0] frame_hist[WINDOW_DEPTH];
    int unsigned hist_head = 0;
    int unsigned hist_fill = 0;
    logic [63:0] hist_sum = '0;
    logic [31:0] avg_ticks = '0;
    logic [63:0] prev_stamp = '0;
    logic [63:0] cur_stamp = '0;
    logic [63:0] origin_stamp = '0;
    logic [63:0] pause_total = '0;
    logic [63:0] halt_stamp = '0;
    logic        halted = 1'b0;
    logic [15:0] frames_seen = '0;
    logic [63:0] rate_span = '0;
    logic [15:0] shown_rate = '0;

    frame_time_average_and_rate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic predict_timing(input ftar_in_t ev, output ftar_out_t res);
        logic [63:0] span;
        logic [31:0] d;
        logic [31:0] dev;
        logic [63:0] total;
        case (ev.kind)
            KIND_TICK:
            begin
                if (halted)
                begin
                    avg_ticks = '0;
                end
                else
                begin
                    cur_stamp = ev.counter_now;
                    span = ev.counter_now - prev_stamp;
                    d = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
                    prev_stamp = ev.counter_now;
                    dev = (d >= avg_ticks) ? d - avg_ticks : avg_ticks - d;
                    if (dev < tps_model)
                    begin
                        if (hist_fill >= WINDOW_DEPTH)
                            hist_sum = hist_sum - frame_hist[hist_head];
                        else
                            hist_fill++;
                        frame_hist[hist_head] = d;
                        hist_sum = hist_sum + d;
                        hist_head = (hist_head + 1) % WINDOW_DEPTH;
                    end
                    if (frames_seen != 16'hFFFF)
                        frames_seen++;
                    rate_span = rate_span + d;
                    if (rate_span > tps_model)
                    begin
                        shown_rate = frames_seen;
                        frames_seen = '0;
                        rate_span = '0;
                    end
                    avg_ticks = (hist_fill > 0) ? 32'(hist_sum / hist_fill) : '0;
                end
            end
            KIND_START:
            begin
                if (halted)
                begin
                    pause_total = pause_total + (ev.counter_now - halt_stamp);
                    prev_stamp = ev.counter_now;
                    halt_stamp = '0;
                    halted = 1'b0;
                end
            end
            KIND_STOP:
            begin
                if (!halted)
                begin
                    halt_stamp = ev.counter_now;
                    halted = 1'b1;
                end
            end
            default:
            begin
                origin_stamp = ev.counter_now;
                prev_stamp = ev.counter_now;
                halt_stamp = '0;
                halted = 1'b0;
            end
        endcase
        total = (halted ? halt_stamp : cur_stamp) - pause_total - origin_stamp;
        if (total[63])
            total = '0;
        res.average_frame_ticks = avg_ticks;
        res.frame_rate = shown_rate;
        res.total_ticks = total[62:0];
        res.is_stopped = halted;
    endtask

    task automatic add_event(input logic [1:0] k, input logic [63:0] c);
        ftar_in_t ev;
        ev.kind = k;
        ev.counter_now = c;
        pending_events.push_back(ev);
    endtask

    // mostly running frames with jitter, plus outliers, pauses, resets and noise
    task automatic queue_phase(input int n, input logic [31:0] tps_val);
        logic [63:0] nominal;
        logic [63:0] jit;
        logic [63:0] delta;
        int sel;
        nominal = 64'(tps_val) / $urandom_range(1, 120);
        if (nominal == 0)
            nominal = 1;
        jit = nominal >> 3;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
            begin
                delta = nominal;
                if (jit != 0 && $urandom_range(0, 2) != 0)
                    delta = nominal - jit + $urandom_range(0, 32'(2 * jit));
                stamp = stamp + delta;
                add_event(KIND_TICK, stamp);
            end
            else if (sel < 80)
            begin
                stamp = stamp + nominal + tps_val + $urandom;
                add_event(KIND_TICK, stamp);
            end
            else if (sel < 82)
            begin
                stamp = {$urandom, $urandom};
                add_event(KIND_TICK, stamp);
            end
            else if (sel < 84)
            begin
                add_event(KIND_TICK, stamp);
            end
            else if (sel < 88)
            begin
                stamp = stamp + $urandom_range(0, nominal[31:0]);
                add_event(KIND_STOP, stamp);
            end
            else if (sel < 95)
            begin
                stamp = stamp + $urandom_range(0, nominal[31:0])
                      + $urandom_range(0, nominal[31:0]);
                add_event(KIND_START, stamp);
            end
            else if (sel < 98)
            begin
                stamp = stamp + $urandom_range(0, 1000);
                add_event(KIND_RESET, stamp);
            end
            else
            begin
                stamp = {$urandom, $urandom};
                add_event(2'($urandom_range(0, 3)), stamp);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || in_valid || expected_timing.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tps(input logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        tps_model = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] phase_tps[7];
        for (int i = 0; i < WINDOW_DEPTH; i++)
            frame_hist[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed events at the reset rate
        add_event(KIND_TICK, 64'd0);
        add_event(KIND_TICK, 64'd166666);
        add_event(KIND_TICK, 64'd333332);
        add_event(KIND_STOP, 64'd400000);
        add_event(KIND_STOP, 64'd500000);
        add_event(KIND_TICK, 64'd450000);
        add_event(KIND_START, 64'd600000);
        add_event(KIND_START, 64'd700000);
        add_event(KIND_TICK, 64'd766666);
        add_event(KIND_TICK, 64'd30766666);
        add_event(KIND_TICK, 64'd100);
        add_event(KIND_RESET, 64'hFFFF_FFFF_FFFF_FFF0);
        add_event(KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
        add_event(KIND_TICK, 64'd5);
        add_event(KIND_RESET, 64'd1000);
        add_event(KIND_TICK, 64'd500);
        add_event(KIND_STOP, 64'd10);
        add_event(KIND_TICK, 64'd20);
        add_event(KIND_START, 64'd30);
        add_event(KIND_TICK, 64'd40);
        stamp = 64'd40;
        wait_drained();

        phase_tps[0] = 32'd1000;
        phase_tps[1] = 32'd1;
        phase_tps[2] = 32'hFFFF_FFFF;
        phase_tps[3] = $urandom_range(1, 32'hFFFF_FFFF);
        phase_tps[4] = TPS_RESET;
        phase_tps[5] = $urandom_range(1, 100000);
        phase_tps[6] = 32'd60000;
        for (int p = 0; p < 7; p++)
        begin
            write_tps(phase_tps[p]);
            idle_on <= (p != 6) && (p % 3 != 2);
            queue_phase(178, phase_tps[p]);
            wait_drained();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // event driver with random sender gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_timing(in_data, want);
                expected_timing.push_back(want);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_events.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    in_gap <= $urandom_range(0, 16);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_events.pop_front();
                end
            end
        end
    end

    // result monitor with random receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_timing.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, actual %p", $time, got);
                end
                else
                begin
                    want = expected_timing.pop_front();
                    if (got.average_frame_ticks !== want.average_frame_ticks)
                    begin
                        errors++;
                        $display("%0t: average_frame_ticks expected %0d actual %0d",
                                 $time, want.average_frame_ticks, got.average_frame_ticks);
                    end
                    if (got.frame_rate !== want.frame_rate)
                    begin
                        errors++;
                        $display("%0t: frame_rate expected %0d actual %0d",
                                 $time, want.frame_rate, got.frame_rate);
                    end
                    if (got.total_ticks !== want.total_ticks)
                    begin
                        errors++;
                        $display("%0t: total_ticks expected %0d actual %0d",
                                 $time, want.total_ticks, got.total_ticks);
                    end
                    if (got.is_stopped !== want.is_stopped)
                    begin
                        errors++;
                        $display("%0t: is_stopped expected %0d actual %0d",
                                 $time, want.is_stopped, got.is_stopped);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_gap <= $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ftar_pkg.sv
rtl/ftar_ram.sv
rtl/ftar_dp.sv
rtl/ftar_ctrl.sv
rtl/frame_time_average_and_rate.sv
bench/tb_frame_time_average_and_rate.sv
